// File: src/fmc_pkg.sv
// Package of shared types and constants for the mixed Fletcher-32 checksum block.
package fmc_pkg;

  // Mixing constants of the stamp hash and the finaliser.
  localparam logic [31:0] StampMul = 32'h9E37_79B9;
  localparam logic [31:0] FinMul1  = 32'h85EB_CA6B;
  localparam logic [31:0] FinMul2  = 32'hC2B2_AE35;
  localparam int unsigned FinShift1 = 13;
  localparam int unsigned FinShift2 = 16;

  // Payload of one input beat.
  typedef struct packed {
    logic [15:0] word;
    logic        word_present;
    logic        last;
    logic [31:0] stamp;
  } in_beat_t;

  // Payload of one result beat.
  typedef struct packed {
    logic [31:0] checksum;
  } out_beat_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN
  } state_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MS_NONE,
    MS_STAMP,
    MS_MIX,
    MS_SHIFT
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     sum_en;
    logic     capture;
    mul_sel_e mul_sel;
    logic     out_load;
  } dp_cmd_t;

endpackage

// File: src/fmc_stream_if.sv
// Valid/ready stream interface that carries one payload per beat.
interface fmc_stream_if #(
  parameter type payload_t = fmc_pkg::in_beat_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/fmc_datapath.sv
// Datapath: Fletcher sums, captured message state and the shared finaliser multiplier.
module fmc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fmc_pkg::dp_cmd_t  cmd_i,
  input  fmc_pkg::in_beat_t beat_i,
  output logic [31:0]       checksum_o
);
  import fmc_pkg::*;

  logic [15:0] low_q, low_d, high_q, high_d;
  logic [16:0] low_add, high_add;
  logic [15:0] low_new, high_new;
  logic [31:0] snap_q, stamp_q, acc_q, res_q;
  logic [31:0] mul_a, mul_b, mul_p;

  // Fletcher update with a single end-around carry fold per sum.
  always_comb begin
    low_add  = {1'b0, low_q} + {1'b0, beat_i.word};
    low_new  = low_add[15:0] + {15'd0, low_add[16]};
    high_add = {1'b0, high_q} + {1'b0, low_new};
    high_new = high_add[15:0] + {15'd0, high_add[16]};
  end

  // The closing beat hands the sums to the finaliser and clears them.
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (cmd_i.capture) begin
      low_d  = '0;
      high_d = '0;
    end else if (cmd_i.sum_en) begin
      low_d  = low_new;
      high_d = high_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // Snapshot of the finished sums and the stamp of the closing beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      snap_q  <= cmd_i.sum_en ? {high_new, low_new} : {high_q, low_q};
      stamp_q <= beat_i.stamp;
    end
  end

  // Shared 32-bit multiplier, product taken modulo 2^32.
  always_comb begin
    mul_a = stamp_q;
    mul_b = StampMul;
    case (cmd_i.mul_sel)
      MS_STAMP: begin
        mul_a = stamp_q;
        mul_b = StampMul;
      end
      MS_MIX: begin
        mul_a = snap_q ^ acc_q;
        mul_b = FinMul1;
      end
      MS_SHIFT: begin
        mul_a = acc_q ^ (acc_q >> FinShift1);
        mul_b = FinMul2;
      end
      default: begin
        mul_a = stamp_q;
        mul_b = StampMul;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != MS_NONE) begin
      acc_q <= mul_p;
    end
  end

  // Last xorshift goes straight into the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q <= acc_q ^ (acc_q >> FinShift2);
    end
  end

  assign checksum_o = res_q;

endmodule

// File: src/fmc_controller.sv
// Controller: input handshake, finaliser sequencing and the result valid flag.
module fmc_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  logic             in_present_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fmc_pkg::dp_cmd_t cmd_o
);
  import fmc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire, out_free;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && in_last_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.sum_en   = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.mul_sel  = MS_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.sum_en  = in_valid_i && in_present_i;
        cmd_o.capture = in_valid_i && in_last_i;
      end
      ST_MUL1: cmd_o.mul_sel = MS_STAMP;
      ST_MUL2: cmd_o.mul_sel = MS_MIX;
      ST_MUL3: cmd_o.mul_sel = MS_SHIFT;
      ST_FIN:  cmd_o.out_load = out_free;
      default: in_ready_o = 1'b0;
    endcase
  end

  // Result valid flag: set on load, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // The finaliser starts only after a closing beat was taken.
  a_start_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL1) |-> $past(in_valid_i && in_ready_o && in_last_i))
    else $error("finaliser started without a closing beat");

  // No beat is taken while a checksum is being finalised.
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input taken while finaliser busy");

  // A new result appears only from the final step.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the final step");
`endif

endmodule

// File: src/fletcher32_mixed_checksum.sv
// Top level of the mixed Fletcher-32 checksum block.
// Takes 16-bit message words one beat at a time and keeps the two Fletcher sums; a beat
// with last set closes the message and, after finalisation, yields one 32-bit checksum
// that mixes in that beat's stamp. A beat without last is taken whenever the block is idle
// and gives no result. A closing beat occupies the block for three passes through the
// single shared 32-bit multiplier (stamp hash, first and second finaliser product) and
// a load into the output register; no input is taken meanwhile, and the load waits if
// the previous result has not yet been taken. No clearing pass follows reset.
module fletcher32_mixed_checksum (
  input  logic         clk_i,
  input  logic         rst_ni,
  fmc_stream_if.sink   in_i,
  fmc_stream_if.source out_o
);
  import fmc_pkg::*;

  dp_cmd_t     cmd;
  logic [31:0] checksum;

  fmc_controller u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_last_i    (in_i.data.last),
    .in_present_i (in_i.data.word_present),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd)
  );

  fmc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .beat_i     (in_i.data),
    .checksum_o (checksum)
  );

  assign out_o.data.checksum = checksum;

endmodule
